[src/f81_transition_probabilities_defines.svh]
// Shared assertion macros for the transition probability block.
`ifndef F81_TRANSITION_PROBABILITIES_DEFINES_SVH
`define F81_TRANSITION_PROBABILITIES_DEFINES_SVH

// Implication checked in the same cycle.
`define F81_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("f81 check failed");

// Implication checked in the next cycle.
`define F81_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("f81 check failed");

`endif

[src/f81_pkg.sv]
`default_nettype none
package f81_pkg;
    localparam int NUM_STATES = 4;
    localparam int CFG_REGS   = 4;
    localparam int STATE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int FREQ_W     = 16;
    localparam int T_W        = 24;
    localparam int X_W        = 20;
    localparam int D_W        = 33;
    localparam int REM_W      = 34;
    localparam int E_W        = 33;
    localparam int S_W        = 34;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;

    typedef logic [FREQ_W-1:0] freq_t;
    typedef freq_t [CFG_REGS-1:0] freq_bank_t;

    // One divider stage: partial remainder and quotient bits so far.
    typedef struct packed {
        logic             valid;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [X_W-1:0]   q;
    } div_st_t;

    // One exponent stage: exponent bits and running product.
    typedef struct packed {
        logic           valid;
        logic           ovf;
        logic [X_W-1:0] x;
        logic [E_W-1:0] e;
    } exp_st_t;

    // exp(-2^(b-16)) in Q0.32.
    function automatic logic [31:0] exp_coef(input logic [4:0] b);
        logic [31:0] c;
        case (b)
            5'd0:    c = 32'd4294901760;
            5'd1:    c = 32'd4294836226;
            5'd2:    c = 32'd4294705160;
            5'd3:    c = 32'd4294443040;
            5'd4:    c = 32'd4293918848;
            5'd5:    c = 32'd4292870656;
            5'd6:    c = 32'd4290775039;
            5'd7:    c = 32'd4286586875;
            5'd8:    c = 32'd4278222805;
            5'd9:    c = 32'd4261543595;
            5'd10:   c = 32'd4228380000;
            5'd11:   c = 32'd4162825044;
            5'd12:   c = 32'd4034748382;
            5'd13:   c = 32'd3790295335;
            5'd14:   c = 32'd3344923893;
            5'd15:   c = 32'd2605029347;
            5'd16:   c = 32'd1580030169;
            5'd17:   c = 32'd581124229;
            5'd18:   c = 32'd78604618;
            5'd19:   c = 32'd1440801;
            default: c = 32'd0;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

[src/f81_div.sv]
`default_nettype none
module f81_div
    import f81_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           adv,
    input  wire logic           in_valid,
    input  wire logic [T_W-1:0] in_t,
    input  wire logic [D_W-1:0] d,
    input  wire logic           dz,
    output div_st_t             out
);
    div_st_t st_reg [X_W+1];
    logic [T_W+11:0]  t_sh;
    logic [REM_W-1:0] init_rem;
    logic             init_ovf;

    // The quotient fits in X_W bits only when t * 2^12 is below the denominator.
    always_comb begin
        t_sh     = {in_t, 12'b0};
        init_ovf = dz || (t_sh >= (T_W+12)'(d));
        init_rem = REM_W'(t_sh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg[0].valid <= 1'b0;
        end else if (adv) begin
            st_reg[0].valid <= in_valid;
        end
        if (adv) begin
            st_reg[0].ovf <= init_ovf;
            st_reg[0].rem <= init_ovf ? '0 : init_rem;
            st_reg[0].q   <= '0;
        end
    end

    // One restoring step per stage, quotient bits most significant first.
    for (genvar i = 0; i < X_W; i++) begin : g_step
        logic [REM_W-1:0] r2;
        logic             ge;
        always_comb begin
            r2 = {st_reg[i].rem[REM_W-2:0], 1'b0};
            ge = r2 >= REM_W'(d);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[i+1].valid <= 1'b0;
            end else if (adv) begin
                st_reg[i+1].valid <= st_reg[i].valid;
            end
            if (adv) begin
                st_reg[i+1].ovf <= st_reg[i].ovf;
                st_reg[i+1].rem <= ge ? (r2 - REM_W'(d)) : r2;
                st_reg[i+1].q   <= {st_reg[i].q[X_W-2:0], ge};
            end
        end
    end

    assign out = st_reg[X_W];
endmodule
`default_nettype wire

[src/f81_exp.sv]
`default_nettype none
module f81_exp
    import f81_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic adv,
    input  div_st_t   in,
    output exp_st_t   out
);
    exp_st_t st_reg [1:X_W];
    exp_st_t head;

    // The product starts at 1.0.
    always_comb begin
        head.valid = in.valid;
        head.ovf   = in.ovf;
        head.x     = in.q;
        head.e     = E_W'(64'h1_0000_0000);
    end

    // Stage b folds in exp(-2^(b-16)) when bit b of the exponent is set.
    for (genvar b = 0; b < X_W; b++) begin : g_mul
        exp_st_t         src;
        logic [E_W+31:0] prod;
        logic [E_W+31:0] rnd;
        if (b == 0) begin : g_head
            assign src = head;
        end else begin : g_prev
            assign src = st_reg[b];
        end
        always_comb begin
            prod = (E_W+32)'(src.e) * (E_W+32)'(exp_coef(5'(b)));
            rnd  = prod + (E_W+32)'(64'h8000_0000);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[b+1].valid <= 1'b0;
            end else if (adv) begin
                st_reg[b+1].valid <= src.valid;
            end
            if (adv) begin
                st_reg[b+1].ovf <= src.ovf;
                st_reg[b+1].x   <= src.x;
                st_reg[b+1].e   <= src.x[b] ? rnd[E_W+31:32] : src.e;
            end
        end
    end

    assign out = st_reg[X_W];
endmodule
`default_nettype wire

[src/f81_emit.sv]
`default_nettype none
module f81_emit
    import f81_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  exp_st_t                     in,
    input  freq_bank_t                  freq,
    output logic                        take,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_OUT_W-1:0]      m_tdata,
    output logic                        m_tlast
);
    localparam logic [STATE_W-1:0] LAST_IDX = STATE_W'(NUM_STATES - 1);
    localparam logic [E_W-1:0]     ONE_E    = E_W'(64'h1_0000_0000);

    logic               busy_reg;
    logic [STATE_W-1:0] row_reg, col_reg;
    logic [E_W-1:0]     e_reg;
    logic               valid_reg, last_reg;
    logic [TDATA_OUT_W-1:0] data_reg;

    logic        out_load, is_last, diag, load;
    freq_t       fi, fj;
    logic [16:0] a;
    logic [E_W-1:0] b;
    logic [49:0] prod, rnd;
    logic [17:0] sum;
    freq_t       p;

    // Entry arithmetic: one shared multiplier for diagonal and off-diagonal.
    always_comb begin
        is_last  = (row_reg == LAST_IDX) && (col_reg == LAST_IDX);
        out_load = busy_reg && (!valid_reg || m_tready);
        take     = !busy_reg || (out_load && is_last);
        load     = take && in.valid;
        diag     = row_reg == col_reg;
        fi       = freq[row_reg];
        fj       = freq[col_reg];
        a        = diag ? (17'h10000 - {1'b0, fi}) : {1'b0, fj};
        b        = diag ? e_reg : (ONE_E - e_reg);
        prod     = 50'(a) * 50'(b);
        rnd      = prod + 50'h8000_0000;
        sum      = (diag ? {2'b0, fi} : 18'd0) + rnd[49:32];
        p        = (sum > 18'd65535) ? 16'hFFFF : sum[15:0];
    end

    // Walk the matrix row by row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
            col_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            row_reg  <= '0;
            col_reg  <= '0;
        end else if (out_load) begin
            if (is_last) begin
                busy_reg <= 1'b0;
            end
            if (col_reg == LAST_IDX) begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
        if (load) begin
            e_reg <= in.ovf ? '0 : in.e;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (out_load) begin
            data_reg <= {4'b0, p, col_reg, row_reg};
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
endmodule
`default_nettype wire

[src/f81_transition_probabilities.sv]
// F81 transition probability matrix: one branch length in, 16 entries out.
// Throughput: the 16 entries leave one per cycle while m_tready holds; the next item is taken as the last entry leaves.
// Register writes are taken only when no item is in flight; input then waits until the new denominator has settled.
// Reset (aresetn low, synchronous) clears valid bits and sets frequencies to 0.25.
`default_nettype none
module f81_transition_probabilities
    import f81_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [TDATA_IN_W-1:0]   s_tdata,   // [23:0] branch_length
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [TDATA_OUT_W-1:0]       m_tdata,   // [1:0] from_state, [3:2] to_state,
                                                    // [19:4] probability, [23:20] zero
    output logic                         m_tlast,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [FREQ_W-1:0]       cfg_data
);
    freq_bank_t       freq_reg;
    logic [31:0]      sq_reg [NUM_STATES];
    logic [D_W-1:0]   d_reg;
    logic             dz_reg;
    logic             in_valid_reg;
    logic [T_W-1:0]   in_t_reg;
    logic [6:0]       flight_reg;
    logic [1:0]       settle_reg;
    logic             adv, take, in_acc, out_done, cfg_acc;
    logic [S_W-1:0]   s_sum;
    div_st_t          div_out;
    exp_st_t          exp_out;

    // Registers change only while the pipeline is empty.
    assign cfg_ready = (flight_reg == 7'd0);
    assign cfg_acc   = cfg_valid && cfg_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CFG_REGS; k++) begin
                freq_reg[k] <= 16'd16384;
            end
        end else if (cfg_acc) begin
            freq_reg[cfg_index] <= cfg_data;
        end
    end

    // Denominator 1 - sum of squared frequencies, refreshed from the registers.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_STATES; k++) begin
            sq_reg[k] <= 32'(freq_reg[k]) * 32'(freq_reg[k]);
        end
        dz_reg <= s_sum >= S_W'(64'h1_0000_0000);
        d_reg  <= D_W'(64'h1_0000_0000) - s_sum[D_W-1:0];
    end

    always_comb begin
        s_sum = '0;
        for (int k = 0; k < NUM_STATES; k++) begin
            s_sum = s_sum + S_W'(sq_reg[k]);
        end
    end

    // Input waits while a new denominator works its way into d_reg.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= 2'd2;
        end else if (cfg_acc) begin
            settle_reg <= 2'd2;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // Count items between acceptance and their final matrix entry.
    assign in_acc   = s_tvalid && s_tready;
    assign out_done = m_tvalid && m_tready && m_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flight_reg <= '0;
        end else if (in_acc && !out_done) begin
            flight_reg <= flight_reg + 7'd1;
        end else if (!in_acc && out_done) begin
            flight_reg <= flight_reg - 7'd1;
        end
    end

    // The whole pipeline moves together unless its last stage waits on the emitter.
    assign adv      = !exp_out.valid || take;
    assign s_tready = adv && (settle_reg == 2'd0) && !cfg_acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= in_acc;
        end
        if (adv) begin
            in_t_reg <= s_tdata[T_W-1:0];
        end
    end

    f81_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (in_valid_reg),
        .in_t     (in_t_reg),
        .d        (d_reg),
        .dz       (dz_reg),
        .out      (div_out)
    );

    f81_exp u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in      (div_out),
        .out     (exp_out)
    );

    f81_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in       (exp_out),
        .freq     (freq_reg),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire

[src/f81_checker.sv]
`default_nettype none
`include "f81_transition_probabilities_defines.svh"
module f81_checker
    import f81_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [TDATA_OUT_W-1:0] m_tdata,
    input wire logic                   m_tlast
);
    // A stalled item stays offered.
    `F81_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // The corner entry of the matrix closes the run.
    `F81_ASSERT_SAME(a_last_corner, aclk, aresetn,
        m_tvalid && m_tdata[1:0] == 2'd3 && m_tdata[3:2] == 2'd3, m_tlast)
    // Only the corner entry closes the run.
    `F81_ASSERT_SAME(a_corner_last, aclk, aresetn,
        m_tvalid && m_tlast, m_tdata[1:0] == 2'd3 && m_tdata[3:2] == 2'd3)
    // Padding bits stay clear.
    `F81_ASSERT_SAME(a_pad, aclk, aresetn, m_tvalid, m_tdata[23:20] == 4'd0)
endmodule

bind f81_transition_probabilities f81_checker u_f81_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
